// ----- sv/topk_pkg.sv -----
package topk_pkg;

  // list geometry
  localparam int MaxKDefault = 16;
  localparam int DistW       = 32;
  localparam int PosW        = 32;
  localparam int SlotW       = 4;
  localparam int KW          = 5;
  localparam int HeldW       = 5;

  localparam logic [DistW-1:0] DistEmpty = '1;
  localparam logic [PosW-1:0]  PosEmpty  = '0;

  // operation codes of the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // one command item
  typedef struct packed {
    logic [1:0]       mode;
    logic [DistW-1:0] cand_distance;
    logic [PosW-1:0]  cand_position;
    logic [SlotW-1:0] read_slot;
  } topk_in_t;

  // one result item
  typedef struct packed {
    logic             inserted;
    logic [HeldW-1:0] held_count;
    logic [DistW-1:0] kth_distance;
    logic [DistW-1:0] slot_distance;
    logic [PosW-1:0]  slot_position;
    logic             slot_filled;
  } topk_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } topk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } topk_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } topk_state_e;

endpackage

// ----- sv/topk_ctrl.sv -----
module topk_ctrl import topk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  topk_sts_t sts_i,
  output topk_cmd_t cmd_o,
  output logic      busy_o
);

  topk_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/topk_dp.sv -----
module topk_dp import topk_pkg::*; #(
  parameter int MaxK = MaxKDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  topk_cmd_t     cmd_i,
  output topk_sts_t     sts_o,
  input  topk_in_t      item_i,
  input  logic          cfg_we_i,
  input  logic [KW-1:0] cfg_wdata_i,
  output logic          done_o,
  output topk_res_t     res_o
);

  localparam int IdxW   = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int CntW   = $clog2(MaxK + 1);
  localparam int SlotCW = (IdxW > SlotW) ? IdxW : SlotW;
  localparam int FillCW = (CntW > SlotW) ? CntW : SlotW;
  localparam int KReset = (MaxK < 16) ? MaxK : 16;

  // list cells, rank order when no scan is running
  logic [DistW-1:0] dist_q [MaxK];
  logic [DistW-1:0] dist_d [MaxK];
  logic [PosW-1:0]  pos_q  [MaxK];
  logic [PosW-1:0]  pos_d  [MaxK];

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [IdxW-1:0]  idx_q;
  topk_in_t         item_q;
  logic             dup_q;
  logic [DistW-1:0] kth_old_q, km2_q, slot_dist_q;
  logic [PosW-1:0]  slot_pos_q;
  logic             done_q;
  topk_res_t        res_q, res_d;

  logic [CntW-1:0]  k_new;
  logic [CntW-1:0]  idx_c;
  logic             full;
  logic [CntW-1:0]  limit;
  logic             do_ins;
  logic [MaxK-1:0]  lt;

  // clamp of the written k
  always_comb begin
    if (cfg_wdata_i == '0) begin
      k_new = CntW'(1);
    end else if (int'(cfg_wdata_i) > MaxK) begin
      k_new = CntW'(MaxK);
    end else begin
      k_new = CntW'(cfg_wdata_i);
    end
  end

  assign idx_c           = CntW'(idx_q);
  assign sts_o.scan_last = (idx_q == IdxW'(MaxK - 1));
  assign full            = (cnt_q == k_q);
  assign limit           = full ? (k_q - CntW'(1)) : cnt_q;
  assign do_ins          = (item_q.mode == MODE_INSERT) && !dup_q;

  // per-cell next value: config trim, scan rotation, clear, and insert with shift down from the insert point
  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    logic prev_lt;
    logic in_range;

    assign lt[i]    = (CntW'(i) < limit) && (dist_q[i] < item_q.cand_distance);
    assign in_range = (CntW'(i) <= limit);

    if (i == 0) begin : g_head
      assign prev_lt = 1'b0;
    end else begin : g_body
      assign prev_lt = lt[i-1];
    end

    always_comb begin
      dist_d[i] = dist_q[i];
      pos_d[i]  = pos_q[i];
      if (cfg_we_i && (CntW'(i) >= k_new)) begin
        dist_d[i] = DistEmpty;
        pos_d[i]  = PosEmpty;
      end else if (cmd_i.scan) begin
        dist_d[i] = dist_q[(i + 1) % MaxK];
        pos_d[i]  = pos_q[(i + 1) % MaxK];
      end else if (cmd_i.apply) begin
        if (item_q.mode == MODE_CLEAR) begin
          dist_d[i] = DistEmpty;
          pos_d[i]  = PosEmpty;
        end else if (do_ins && !lt[i] && in_range) begin
          if (i == 0 || !prev_lt) begin
            if (i == 0 || prev_lt == lt[i]) begin
              dist_d[i] = dist_q[(i + MaxK - 1) % MaxK];
              pos_d[i]  = pos_q[(i + MaxK - 1) % MaxK];
            end
          end
          if (i == 0 || prev_lt) begin
            dist_d[i] = item_q.cand_distance;
            pos_d[i]  = item_q.cand_position;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dist_q[i] <= DistEmpty;
        pos_q[i]  <= PosEmpty;
      end else begin
        dist_q[i] <= dist_d[i];
        pos_q[i]  <= pos_d[i];
      end
    end
  end

  // fill count and k
  always_comb begin
    cnt_d = cnt_q;
    k_d   = k_q;
    if (cfg_we_i) begin
      k_d = k_new;
      if (cnt_q > k_new) begin
        cnt_d = k_new;
      end
    end else if (cmd_i.apply) begin
      if (item_q.mode == MODE_CLEAR) begin
        cnt_d = '0;
      end else if (do_ins) begin
        cnt_d = full ? k_q : (cnt_q + CntW'(1));
      end
    end
  end

  // result of the step
  always_comb begin
    logic becomes_full;
    logic slot_hit;
    becomes_full        = full || ((cnt_q + CntW'(1)) == k_q);
    slot_hit            = FillCW'(item_q.read_slot) < FillCW'(cnt_q);
    res_d               = '0;
    res_d.inserted      = do_ins;
    res_d.held_count    = HeldW'(cnt_d);
    res_d.slot_distance = DistEmpty;
    res_d.slot_position = PosEmpty;
    res_d.kth_distance  = kth_old_q;
    if (item_q.mode == MODE_CLEAR) begin
      res_d.kth_distance = DistEmpty;
    end else if (do_ins && becomes_full) begin
      if (k_q == CntW'(1) || item_q.cand_distance > km2_q) begin
        res_d.kth_distance = item_q.cand_distance;
      end else begin
        res_d.kth_distance = km2_q;
      end
    end
    if (item_q.mode == MODE_READ && slot_hit) begin
      res_d.slot_distance = slot_dist_q;
      res_d.slot_position = slot_pos_q;
      res_d.slot_filled   = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      k_q    <= CntW'(KReset);
      idx_q  <= '0;
      dup_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      k_q    <= k_d;
      done_q <= cmd_i.apply;
      if (cmd_i.load) begin
        idx_q <= '0;
        dup_q <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q <= sts_o.scan_last ? '0 : (idx_q + IdxW'(1));
        if ((idx_c < cnt_q) && (dist_q[0] == item_q.cand_distance)) begin
          dup_q <= 1'b1;
        end
      end
    end
  end

  // item latch, captures from the head cell during the scan, and the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.scan) begin
      if (idx_c == (k_q - CntW'(1))) begin
        kth_old_q <= dist_q[0];
      end
      if ((idx_c + CntW'(2)) == k_q) begin
        km2_q <= dist_q[0];
      end
      if (SlotCW'(idx_q) == SlotCW'(item_q.read_slot)) begin
        slot_dist_q <= dist_q[0];
        slot_pos_q  <= pos_q[0];
      end
    end
    if (cmd_i.apply) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- sv/bounded_sorted_topk_list_core.sv -----
// channel   signals                      accepted when
// command   start, busy, cmd_i           start high and busy low at a rising edge
// config    cfg_we_i, cfg_wdata_i        cfg_we_i high at a rising edge
// result    done_o, res_o                done_o high, for one cycle only
//
// each item is latched, then the list rotates once through the head cell,
// then the item is applied; the next item can start with done_o
// the rotation of the cell chain sets the item period
// reset empties the list, clears the count and sets k to 16 (or MaxK if less)
// the receiver cannot stall: done_o flags each result for exactly one cycle
module bounded_sorted_topk_list_core import topk_pkg::*; #(
  parameter int MaxK = MaxKDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  topk_in_t      cmd_i,
  input  logic          cfg_we_i,
  input  logic [KW-1:0] cfg_wdata_i,
  output logic          done_o,
  output topk_res_t     res_o
);

  topk_cmd_t ctl_cmd;
  topk_sts_t dp_sts;

  // sequencer
  topk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (dp_sts),
    .cmd_o  (ctl_cmd),
    .busy_o (busy)
  );

  // list cells and result path
  topk_dp #(
    .MaxK(MaxK)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctl_cmd),
    .sts_o      (dp_sts),
    .item_i     (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ----- sv/topk_chk.sv -----
module topk_chk import topk_pkg::*; #(
  parameter int MaxK = MaxKDefault
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input topk_res_t res_o
);

  // an accepted item keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result comes out only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  // count never beyond the list size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(res_o.held_count) <= MaxK))
    else $error("held count beyond list size");

  // an empty read shows the empty entry
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.slot_filled |->
      (res_o.slot_distance == DistEmpty) && (res_o.slot_position == PosEmpty))
    else $error("empty read shows data");

  // a successful insert leaves at least one entry
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.inserted |-> (res_o.held_count != '0))
    else $error("insert left the list empty");

endmodule

bind bounded_sorted_topk_list_core topk_chk #(
  .MaxK(MaxK)
) u_topk_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);
